@@ sv/slice_prb_share_rebalancer_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the slice share rebalancer
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef SLICE_PRB_SHARE_REBALANCER_ASSERT_SVH
`define SLICE_PRB_SHARE_REBALANCER_ASSERT_SVH

// Same-cycle implication.
`define SPR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SPR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/spr_pkg.sv @@
// ---------------------------------------------------------------------------
// spr_pkg: shared types and constants of the slice share rebalancer
// Codes, reset values, controller/datapath interface structs, action decode.
// ---------------------------------------------------------------------------
package spr_pkg;

  localparam int SHARE_BITS_DEF = 9;
  localparam int PASS_LIMIT_DEF = 100;
  localparam int ACTION_COUNT   = 27;

  localparam int RST_TOTAL   = 100;
  localparam int RST_SHARE_A = 34;
  localparam int RST_SHARE_B = 33;
  localparam int RST_SHARE_C = 33;

  typedef enum logic [1:0] {
    CFG_TOTAL  = 2'd0,
    CFG_INIT_A = 2'd1,
    CFG_INIT_B = 2'd2,
    CFG_INIT_C = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_ACTION = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_START  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_REVERT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_SUM,
    S_GROW,
    S_SHRINK,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic    tick;
    logic    start;
    logic    latch;
    logic    apply;
    logic    sum_load;
    logic    grow_step;
    logic    shrink_step;
    logic    revert;
    logic    out_load;
    status_e out_status;
  } cmd_t;

  typedef struct packed {
    logic sum_lt;
    logic sum_gt;
    logic shr_done;
    logic shr_revert;
  } sts_t;

  typedef logic [2:0][1:0] digits_t;

  // Split an action code into its three base-3 digits, most significant
  // digit first (slice 0).
  function automatic digits_t decode_digits(input logic [4:0] a);
    logic [1:0] d0;
    logic [1:0] d1;
    logic [4:0] r1;
    logic [4:0] r2;
    digits_t    f;
    d0 = (a >= 5'd18) ? 2'd2 : ((a >= 5'd9) ? 2'd1 : 2'd0);
    r1 = a - ({3'b000, d0} * 5'd9);
    d1 = (r1 >= 5'd6) ? 2'd2 : ((r1 >= 5'd3) ? 2'd1 : 2'd0);
    r2 = r1 - ({3'b000, d1} * 5'd3);
    f[0] = d0;
    f[1] = d1;
    f[2] = r2[1:0];
    return f;
  endfunction

endpackage

@@ sv/spr_dp.sv @@
// ---------------------------------------------------------------------------
// spr_dp: share datapath
// Config registers, slice shares, running sum, shrink-pass bookkeeping and
// the result register.
// ---------------------------------------------------------------------------
module spr_dp #(
  parameter int SHARE_BITS = spr_pkg::SHARE_BITS_DEF,
  parameter int PASS_LIMIT = spr_pkg::PASS_LIMIT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [SHARE_BITS-1:0] cfg_data_i,
  input  logic [4:0]            action_id_i,
  input  spr_pkg::cmd_t         cmd_i,
  output spr_pkg::sts_t         sts_o,
  output logic [SHARE_BITS-1:0] share_a_o,
  output logic [SHARE_BITS-1:0] share_b_o,
  output logic [SHARE_BITS-1:0] share_c_o,
  output logic [1:0]            status_o
);

  localparam int SW   = SHARE_BITS + 1;
  localparam int SUMW = SHARE_BITS + 2;
  localparam int PW   = $clog2(PASS_LIMIT + 2);

  logic [SHARE_BITS-1:0] total_q;
  logic [SHARE_BITS-1:0] init_q [3];
  logic [SW-1:0]         share_q [3];
  logic [SW-1:0]         share_d [3];
  logic [1:0]            rot_q, rot_d;

  logic [SUMW-1:0]       sum_q, sum_d;
  logic [1:0]            ptr_q, ptr_d;
  logic [1:0]            visit_q, visit_d;
  logic                  removed_q, removed_d;
  logic [PW-1:0]         pass_q, pass_d;
  logic [4:0]            act_q;
  logic [SHARE_BITS-1:0] out_share_q [3];
  spr_pkg::status_e      out_status_q;

  spr_pkg::digits_t      digit;
  logic [1:0]            min_idx;
  logic                  dec;
  logic [SUMW-1:0]       sum_n;
  logic [SUMW-1:0]       total_ext;
  logic                  removed_n;
  logic                  pass_end;
  logic [PW:0]           pass_inc;
  logic                  over;
  logic [SW:0]           applied [3];

  assign digit     = spr_pkg::decode_digits(act_q);
  assign total_ext = SUMW'(total_q);
  assign dec       = share_q[ptr_q] > SW'(1);
  assign sum_n     = sum_q - SUMW'(dec);
  assign removed_n = removed_q | dec;
  assign pass_end  = (visit_q == 2'd2) || (sum_n == total_ext);
  assign pass_inc  = {1'b0, pass_q} + (PW+1)'(1);
  assign over      = pass_inc > (PW+1)'(PASS_LIMIT);

  assign sts_o.sum_lt     = sum_q < total_ext;
  assign sts_o.sum_gt     = sum_q > total_ext;
  assign sts_o.shr_revert = pass_end && (!removed_n || over);
  assign sts_o.shr_done   = pass_end && removed_n && !over && (sum_n == total_ext);

  // Lowest-index smallest slice.
  always_comb begin
    min_idx = 2'd0;
    if (share_q[1] < share_q[0]) begin
      min_idx = 2'd1;
    end
    if (share_q[2] < share_q[min_idx]) begin
      min_idx = 2'd2;
    end
  end

  always_comb begin
    for (int s = 0; s < 3; s++) begin
      applied[s] = {1'b0, share_q[s]} + (SW+1)'(digit[s]);
      share_d[s] = share_q[s];
      if (cmd_i.revert || cmd_i.start) begin
        share_d[s] = SW'(init_q[s]);
      end else if (cmd_i.apply) begin
        share_d[s] = (applied[s] >= (SW+1)'(2)) ? SW'(applied[s] - (SW+1)'(1)) : SW'(1);
      end else if (cmd_i.grow_step && (min_idx == 2'(s))) begin
        share_d[s] = share_q[s] + SW'(1);
      end else if (cmd_i.shrink_step && (ptr_q == 2'(s)) && dec) begin
        share_d[s] = share_q[s] - SW'(1);
      end
    end
  end

  always_comb begin
    rot_d = rot_q;
    if (cmd_i.start) begin
      rot_d = 2'd0;
    end else if (cmd_i.tick) begin
      rot_d = (rot_q == 2'd2) ? 2'd0 : rot_q + 2'd1;
    end
  end

  always_comb begin
    sum_d     = sum_q;
    ptr_d     = ptr_q;
    visit_d   = visit_q;
    removed_d = removed_q;
    pass_d    = pass_q;
    if (cmd_i.sum_load) begin
      sum_d     = SUMW'(share_q[0]) + SUMW'(share_q[1]) + SUMW'(share_q[2]);
      ptr_d     = rot_q;
      visit_d   = 2'd0;
      removed_d = 1'b0;
      pass_d    = '0;
    end else if (cmd_i.grow_step) begin
      sum_d = sum_q + SUMW'(1);
    end else if (cmd_i.shrink_step) begin
      sum_d = sum_n;
      ptr_d = (ptr_q == 2'd2) ? 2'd0 : ptr_q + 2'd1;
      if (pass_end) begin
        visit_d   = 2'd0;
        removed_d = 1'b0;
        pass_d    = pass_inc[PW-1:0];
      end else begin
        visit_d   = visit_q + 2'd1;
        removed_d = removed_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= SHARE_BITS'(spr_pkg::RST_TOTAL);
      init_q[0]  <= SHARE_BITS'(spr_pkg::RST_SHARE_A);
      init_q[1]  <= SHARE_BITS'(spr_pkg::RST_SHARE_B);
      init_q[2]  <= SHARE_BITS'(spr_pkg::RST_SHARE_C);
      share_q[0] <= SW'(spr_pkg::RST_SHARE_A);
      share_q[1] <= SW'(spr_pkg::RST_SHARE_B);
      share_q[2] <= SW'(spr_pkg::RST_SHARE_C);
      rot_q      <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          spr_pkg::CFG_TOTAL:  total_q   <= cfg_data_i;
          spr_pkg::CFG_INIT_A: init_q[0] <= cfg_data_i;
          spr_pkg::CFG_INIT_B: init_q[1] <= cfg_data_i;
          spr_pkg::CFG_INIT_C: init_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      share_q <= share_d;
      rot_q   <= rot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q     <= sum_d;
    ptr_q     <= ptr_d;
    visit_q   <= visit_d;
    removed_q <= removed_d;
    pass_q    <= pass_d;
    if (cmd_i.latch) begin
      act_q <= action_id_i;
    end
    if (cmd_i.out_load) begin
      for (int s = 0; s < 3; s++) begin
        out_share_q[s] <= share_q[s][SHARE_BITS-1:0];
      end
      out_status_q <= cmd_i.out_status;
    end
  end

  assign share_a_o = out_share_q[0];
  assign share_b_o = out_share_q[1];
  assign share_c_o = out_share_q[2];
  assign status_o  = out_status_q;

endmodule

@@ sv/spr_ctrl.sv @@
// ---------------------------------------------------------------------------
// spr_ctrl: sequencing controller
// Takes one item, steps an action through apply, sum, grow and shrink,
// and hands every result to the output register.
// ---------------------------------------------------------------------------
module spr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    kind_i,
  input  logic [4:0]    action_id_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  spr_pkg::sts_t sts_i,
  output spr_pkg::cmd_t cmd_o
);

  spr_pkg::state_e  state_q, state_d;
  spr_pkg::status_e status_q, status_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.out_status = status_q;
    case (state_q)
      spr_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          status_d = spr_pkg::ST_OK;
          state_d  = spr_pkg::S_FINISH;
          case (kind_i)
            spr_pkg::KIND_ACTION: begin
              if (action_id_i >= 5'(spr_pkg::ACTION_COUNT)) begin
                status_d = spr_pkg::ST_REJECT;
              end else begin
                cmd_o.latch = 1'b1;
                state_d     = spr_pkg::S_APPLY;
              end
            end
            spr_pkg::KIND_TICK:  cmd_o.tick  = 1'b1;
            spr_pkg::KIND_START: cmd_o.start = 1'b1;
            default: ;
          endcase
        end
      end
      spr_pkg::S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = spr_pkg::S_SUM;
      end
      spr_pkg::S_SUM: begin
        cmd_o.sum_load = 1'b1;
        state_d        = spr_pkg::S_GROW;
      end
      spr_pkg::S_GROW: begin
        if (sts_i.sum_lt) begin
          cmd_o.grow_step = 1'b1;
        end else if (sts_i.sum_gt) begin
          state_d = spr_pkg::S_SHRINK;
        end else begin
          status_d = spr_pkg::ST_OK;
          state_d  = spr_pkg::S_FINISH;
        end
      end
      spr_pkg::S_SHRINK: begin
        cmd_o.shrink_step = 1'b1;
        if (sts_i.shr_revert) begin
          cmd_o.revert = 1'b1;
          status_d     = spr_pkg::ST_REVERT;
          state_d      = spr_pkg::S_FINISH;
        end else if (sts_i.shr_done) begin
          status_d = spr_pkg::ST_OK;
          state_d  = spr_pkg::S_FINISH;
        end
      end
      spr_pkg::S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = spr_pkg::S_IDLE;
        end
      end
      default: state_d = spr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spr_pkg::S_IDLE;
      status_q    <= spr_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/slice_prb_share_rebalancer.sv @@
// ---------------------------------------------------------------------------
// slice_prb_share_rebalancer: three-slice resource block share rebalancer
// Sequence: tick, start, rejected and ignored items go straight to the result
//   load; an action steps through apply, sum, G grow steps and V shrink
//   visits (V at most 3*(PASS_LIMIT+1)), one unit per cycle on the share adder.
// Throughput: one item in work at a time; the next transfer is taken the cycle
//   after the result load, and that load waits while a held result is pending.
// Reset: shares 34/33/33, total 100, rotation 0, no result pending.
// ---------------------------------------------------------------------------
module slice_prb_share_rebalancer #(
  parameter int SHARE_BITS = spr_pkg::SHARE_BITS_DEF,
  parameter int PASS_LIMIT = spr_pkg::PASS_LIMIT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [SHARE_BITS-1:0] cfg_data_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            kind_i,
  input  logic [4:0]            action_id_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SHARE_BITS-1:0] share_a_o,
  output logic [SHARE_BITS-1:0] share_b_o,
  output logic [SHARE_BITS-1:0] share_c_o,
  output logic [1:0]            status_o
);

  // Command and status buses between the sequencer and the datapath.
  spr_pkg::cmd_t cmd;
  spr_pkg::sts_t sts;

  // Sequencer: accepts one transfer in idle, walks the action through
  // apply (delta plus floor), sum, grow (one unit per cycle to the smallest
  // slice) and shrink (one slice visit per cycle from the rotation index),
  // then parks the result in the output register. A result still waiting
  // for its transfer does not stop the next item from being taken; only
  // the final load waits for the register to free up.
  spr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .action_id_i (action_id_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: holds the config registers, the shares, the running sum and
  // the pass counter; reports sum compares and the end-of-pass verdict
  // (finished, or revert on an empty pass or past the pass limit).
  spr_dp #(
    .SHARE_BITS (SHARE_BITS),
    .PASS_LIMIT (PASS_LIMIT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .action_id_i (action_id_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .share_a_o   (share_a_o),
    .share_b_o   (share_b_o),
    .share_c_o   (share_c_o),
    .status_o    (status_o)
  );

  // Checks: hold off new transfers while an item is in work, free the
  // input side whenever a fresh result appears, and turn ticks around fast.
`include "slice_prb_share_rebalancer_assert.svh"

  `SPR_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "input taken while busy")
  `SPR_ASSERT_IMP(a_result_frees_input, $rose(out_valid_o), in_ready_o, "result without idle")
  `SPR_ASSERT_NXT(a_tick_result, in_valid_i && in_ready_o && kind_i == spr_pkg::KIND_TICK, ##1 out_valid_o, "tick result late")

endmodule

@@ sim/slice_prb_share_rebalancer_tb.sv @@
// ---------------------------------------------------------------------------
// slice_prb_share_rebalancer_tb: self-checking bench of the share rebalancer
// Drives tick, start, action, rejected and ignored items through the input
// channel. Random gaps on both channels. Each result is compared with the
// counts and status that a behavioral copy of the rebalancer computes when
// the item is accepted.
// ---------------------------------------------------------------------------
module slice_prb_share_rebalancer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // kind code that the block ignores
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  // action codes: digits give +1 (2), hold (1), -1 (0) for slices 0, 1, 2
  localparam logic [4:0] ACT_ALL_DOWN   = 5'd0;
  localparam logic [4:0] ACT_HOLD       = 5'd13;
  localparam logic [4:0] ACT_UP_UP_HOLD = 5'd25;
  localparam logic [4:0] ACT_ALL_UP     = 5'd26;
  localparam logic [4:0] ACT_MAX        = 5'd31;

  localparam logic [8:0] SHARE_MAX      = 9'd511;

  // settle time after the last result before a register write
  localparam int unsigned IDLE_SETTLE   = 4;
  // worst action: grow to the full total plus every shrink visit
  localparam int unsigned DRAIN_CYCLES  = 1000;
  localparam longint unsigned RUN_LIMIT_NS = 25_000_000;

  typedef struct packed {
    logic [8:0]          share_a;
    logic [8:0]          share_b;
    logic [8:0]          share_c;
    spr_pkg::status_e    status;
  } slice_shares_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [8:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] kind_i;
  logic [4:0] action_id_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [8:0] share_a_o;
  logic [8:0] share_b_o;
  logic [8:0] share_c_o;
  logic [1:0] status_o;

  // expected results in transfer order
  slice_shares_t shares_due[$];
  int unsigned   mismatches = 0;
  // set for back-to-back stretches: no gaps on either channel
  bit            steady_flow = 1'b0;
  int unsigned   rx_stall = 0;

  // behavioral copy of the rebalancer: counts, rotation and registers
  logic [9:0] model_share [3];
  logic [1:0] model_rot;
  logic [8:0] model_total;
  logic [8:0] model_init  [3];

  slice_prb_share_rebalancer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .action_id_i (action_id_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .share_a_o   (share_a_o),
    .share_b_o   (share_b_o),
    .share_c_o   (share_c_o),
    .status_o    (status_o)
  );

  always #5 clk_i = ~clk_i;

  // -------------------------------------------------------------------------
  // Prediction
  // -------------------------------------------------------------------------

  function automatic void load_initial_shares();
    int unsigned k;
    for (k = 0; k < 3; k++) model_share[k] = {1'b0, model_init[k]};
  endfunction

  // Bring the counts to the total; return 1 when they must fall back.
  function automatic bit rebalance_slices();
    int unsigned sum;
    int unsigned passes;
    int unsigned low;
    int unsigned pos;
    int unsigned i;
    bit          took;
    sum    = model_share[0] + model_share[1] + model_share[2];
    passes = 0;
    // grow: one unit to the lowest-index smallest slice
    while (sum < model_total) begin
      low = 0;
      for (i = 1; i < 3; i++) begin
        if (model_share[i] < model_share[low]) low = i;
      end
      model_share[low] = model_share[low] + 10'd1;
      sum++;
    end
    // shrink: passes start at the rotation index, skip slices at 1
    while (sum > model_total) begin
      took = 1'b0;
      for (i = 0; i < 3 && sum > model_total; i++) begin
        pos = (model_rot + i) % 3;
        if (model_share[pos] > 10'd1) begin
          model_share[pos] = model_share[pos] - 10'd1;
          sum--;
          took = 1'b1;
        end
      end
      if (!took) return 1'b1;
      passes++;
      // the pass past the limit reverts even when it hit the total
      if (passes > spr_pkg::PASS_LIMIT_DEF) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic slice_shares_t predict_shares(input logic [1:0] kind,
                                                   input logic [4:0] act);
    slice_shares_t res;
    int unsigned   digit [3];
    int unsigned   v;
    int unsigned   k;
    res.status = spr_pkg::ST_OK;
    case (kind)
      spr_pkg::KIND_ACTION: begin
        if (act >= spr_pkg::ACTION_COUNT) begin
          res.status = spr_pkg::ST_REJECT;
        end else begin
          digit[0] = act / 9;
          digit[1] = (act / 3) % 3;
          digit[2] = act % 3;
          // apply delta, floor at one
          for (k = 0; k < 3; k++) begin
            v = model_share[k] + digit[k];
            model_share[k] = (v >= 2) ? 10'(v - 1) : 10'd1;
          end
          if (rebalance_slices()) begin
            load_initial_shares();
            res.status = spr_pkg::ST_REVERT;
          end
        end
      end
      spr_pkg::KIND_TICK: begin
        model_rot = (model_rot == 2'd2) ? 2'd0 : model_rot + 2'd1;
      end
      spr_pkg::KIND_START: begin
        load_initial_shares();
        model_rot = 2'd0;
      end
      default: begin
      end
    endcase
    res.share_a = model_share[0][8:0];
    res.share_b = model_share[1][8:0];
    res.share_c = model_share[2][8:0];
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // Channel helpers
  // -------------------------------------------------------------------------

  // Mostly no gap, often a short one, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Send one item; predict its result at the transfer.
  task automatic send_item(input logic [1:0] kind, input logic [4:0] act);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    // keep valid high across back-to-back items, change only the payload
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    action_id_i <= act;
    do @(posedge clk_i); while (!in_ready_o);
    shares_due.push_back(predict_shares(kind, act));
  endtask

  // Hold the sender until every expected result has arrived.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (shares_due.size() != 0) @(posedge clk_i);
    repeat (IDLE_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input spr_pkg::cfg_idx_e idx, input logic [8:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  // Write all four registers; only call with the block idle.
  task automatic write_config(input logic [8:0] total, input logic [8:0] a,
                              input logic [8:0] b, input logic [8:0] c);
    write_reg(spr_pkg::CFG_TOTAL, total);
    write_reg(spr_pkg::CFG_INIT_A, a);
    write_reg(spr_pkg::CFG_INIT_B, b);
    write_reg(spr_pkg::CFG_INIT_C, c);
    cfg_we_i      <= 1'b0;
    model_total   = total;
    model_init[0] = a;
    model_init[1] = b;
    model_init[2] = c;
  endtask

  // -------------------------------------------------------------------------
  // Result side: random stalls and checking
  // -------------------------------------------------------------------------

  // Random stalls on ready; ready goes high again between any two stalls.
  always @(posedge clk_i) begin
    if (rx_stall != 0) begin
      out_ready_i <= 1'b0;
      rx_stall    <= rx_stall - 1;
    end else begin
      out_ready_i <= 1'b1;
      rx_stall    <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
    end
  end

  always @(posedge clk_i) begin : check_results
    slice_shares_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (shares_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result a=%0d b=%0d c=%0d status=%0d",
                   $realtime, share_a_o, share_b_o, share_c_o, status_o);
      end else begin
        want = shares_due.pop_front();
        if (share_a_o !== want.share_a || share_b_o !== want.share_b ||
            share_c_o !== want.share_c || status_o !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected %0d/%0d/%0d st %0d, got %0d/%0d/%0d st %0d",
                     $realtime, want.share_a, want.share_b, want.share_c,
                     want.status, share_a_o, share_b_o, share_c_o, status_o);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Reset counts, rejects, ignored kind, grow and shrink.
  task automatic test_reset_state();
    send_item(spr_pkg::KIND_ACTION, ACT_HOLD);
    send_item(KIND_IGNORED, ACT_MAX);
    send_item(spr_pkg::KIND_ACTION, 5'(spr_pkg::ACTION_COUNT));
    send_item(spr_pkg::KIND_ACTION, ACT_MAX);
    send_item(spr_pkg::KIND_ACTION, ACT_ALL_DOWN);
    send_item(spr_pkg::KIND_ACTION, ACT_ALL_UP);
    send_item(spr_pkg::KIND_START, ACT_MAX);
  endtask

  // Shrink order follows the rotation index, including its wrap to zero.
  task automatic test_rotation();
    send_item(spr_pkg::KIND_TICK, ACT_ALL_DOWN);
    send_item(spr_pkg::KIND_ACTION, ACT_UP_UP_HOLD);
    send_item(spr_pkg::KIND_TICK, ACT_MAX);
    send_item(spr_pkg::KIND_ACTION, ACT_UP_UP_HOLD);
    send_item(spr_pkg::KIND_TICK, ACT_HOLD);
    send_item(spr_pkg::KIND_ACTION, ACT_UP_UP_HOLD);
  endtask

  // Full-scale and zero register values.
  task automatic test_extreme_shares();
    wait_for_results();
    write_config(SHARE_MAX, SHARE_MAX, 9'd0, 9'd0);
    send_item(spr_pkg::KIND_START, ACT_HOLD);
    send_item(spr_pkg::KIND_ACTION, ACT_HOLD);
    send_item(spr_pkg::KIND_ACTION, ACT_ALL_DOWN);
    send_item(spr_pkg::KIND_ACTION, ACT_ALL_UP);
  endtask

  // Zero total and all counts at one: a pass that removes nothing reverts.
  task automatic test_stuck_pass();
    wait_for_results();
    write_config(9'd0, 9'd0, 9'd0, 9'd0);
    send_item(spr_pkg::KIND_START, ACT_HOLD);
    send_item(spr_pkg::KIND_ACTION, ACT_HOLD);
    wait_for_results();
    write_config(9'd2, 9'd1, 9'd1, 9'd1);
    send_item(spr_pkg::KIND_START, ACT_HOLD);
    send_item(spr_pkg::KIND_ACTION, ACT_HOLD);
  endtask

  // Excess of 300 needs exactly the pass limit; 301 needs one pass more.
  task automatic test_pass_limit();
    wait_for_results();
    write_config(9'd300, 9'd200, 9'd200, 9'd200);
    send_item(spr_pkg::KIND_START, ACT_HOLD);
    send_item(spr_pkg::KIND_ACTION, ACT_HOLD);
    wait_for_results();
    write_config(9'd299, 9'd200, 9'd200, 9'd200);
    send_item(spr_pkg::KIND_START, ACT_HOLD);
    send_item(spr_pkg::KIND_ACTION, ACT_HOLD);
  endtask

  // Random mix, mostly valid actions; ignored items do not count.
  task automatic run_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned r;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_item(spr_pkg::KIND_ACTION,
                  5'($urandom_range(0, spr_pkg::ACTION_COUNT - 1)));
      end else if (r < 82) begin
        send_item(spr_pkg::KIND_TICK, 5'($urandom_range(0, ACT_MAX)));
      end else if (r < 88) begin
        send_item(spr_pkg::KIND_START, 5'($urandom_range(0, ACT_MAX)));
      end else if (r < 95) begin
        send_item(spr_pkg::KIND_ACTION,
                  5'($urandom_range(spr_pkg::ACTION_COUNT, ACT_MAX)));
      end else begin
        send_item(KIND_IGNORED, 5'($urandom_range(0, ACT_MAX)));
        sent--;
      end
      sent++;
      // now and then let the block run dry before the next item
      if ($urandom_range(0, 49) == 0) wait_for_results();
    end
  endtask

  task automatic test_random_default();
    wait_for_results();
    write_config(9'(spr_pkg::RST_TOTAL), 9'(spr_pkg::RST_SHARE_A),
                 9'(spr_pkg::RST_SHARE_B), 9'(spr_pkg::RST_SHARE_C));
    send_item(spr_pkg::KIND_START, ACT_HOLD);
    run_traffic(100);
  endtask

  // Random totals with initial shares up to half the total plus one; last phase full range.
  task automatic test_random_configs();
    int unsigned phase;
    logic [8:0]  total;
    for (phase = 0; phase < 4; phase++) begin
      wait_for_results();
      if (phase == 3) begin
        write_config(SHARE_MAX, 9'($urandom_range(0, SHARE_MAX)),
                     9'($urandom_range(0, SHARE_MAX)), 9'($urandom_range(0, SHARE_MAX)));
      end else begin
        total = 9'($urandom_range(1, SHARE_MAX));
        write_config(total, 9'($urandom_range(0, total / 2 + 1)),
                     9'($urandom_range(0, total / 2 + 1)),
                     9'($urandom_range(0, total / 2 + 1)));
      end
      send_item(spr_pkg::KIND_START, ACT_HOLD);
      run_traffic(70);
    end
  endtask

  // Totals from one to six: floors, stuck passes and reverts are common.
  task automatic test_random_small_totals();
    int unsigned phase;
    for (phase = 0; phase < 3; phase++) begin
      wait_for_results();
      write_config(9'($urandom_range(1, 6)), 9'($urandom_range(0, 3)),
                   9'($urandom_range(0, 3)), 9'($urandom_range(0, 3)));
      send_item(spr_pkg::KIND_START, ACT_HOLD);
      run_traffic(20);
    end
  endtask

  // No gaps on either channel.
  task automatic test_back_to_back();
    wait_for_results();
    write_config(9'($urandom_range(30, 200)), 9'($urandom_range(0, 80)),
                 9'($urandom_range(0, 80)), 9'($urandom_range(0, 80)));
    steady_flow = 1'b1;
    send_item(spr_pkg::KIND_START, ACT_HOLD);
    run_traffic(60);
    steady_flow = 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= spr_pkg::CFG_TOTAL;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    kind_i      <= spr_pkg::KIND_ACTION;
    action_id_i <= ACT_HOLD;
    // registers and counts as after reset
    model_total   = 9'(spr_pkg::RST_TOTAL);
    model_init[0] = 9'(spr_pkg::RST_SHARE_A);
    model_init[1] = 9'(spr_pkg::RST_SHARE_B);
    model_init[2] = 9'(spr_pkg::RST_SHARE_C);
    load_initial_shares();
    model_rot     = 2'd0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_rotation();
    test_extreme_shares();
    test_stuck_pass();
    test_pass_limit();
    test_random_default();
    test_random_configs();
    test_random_small_totals();
    test_back_to_back();

    // drain, then watch for stray results over a worst-case action
    in_valid_i <= 1'b0;
    while (shares_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && shares_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #RUN_LIMIT_NS;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/spr_pkg.sv
sv/spr_dp.sv
sv/spr_ctrl.sv
sv/slice_prb_share_rebalancer.sv
sim/slice_prb_share_rebalancer_tb.sv
